[src/take_back_half_velocity_control_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef TAKE_BACK_HALF_VELOCITY_CONTROL_ASSERT_SVH
`define TAKE_BACK_HALF_VELOCITY_CONTROL_ASSERT_SVH

// Condition and consequence in the same cycle.
`define TBH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define TBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tbh_pkg.sv]
package tbh_pkg;

    // Fixed-point formats of the controller.
    localparam int DRIVE_FRAC_BITS = 16;
    localparam int GAIN_FRAC_BITS  = 24;
    localparam int MAX_COMMAND     = 127;

    // Field widths.
    localparam int RPM_W    = 11;
    localparam int TARGET_W = 14;
    localparam int GEAR_W   = 4;
    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = DRIVE_FRAC_BITS + 1;
    localparam int CMD_W    = 7;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    // Error is a 16-bit signed value whose magnitude stays below 2**15, so it fits 15 bits.
    localparam int ERR_W   = 16;
    localparam int MAG_W   = ERR_W - 1;
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int SHIFT   = GAIN_FRAC_BITS - DRIVE_FRAC_BITS;
    localparam int DELTA_W = PROD_W - SHIFT + 1;
    localparam int SUM_W   = DELTA_W + 2;
    localparam int CMDP_W  = DRIVE_W + CMD_W;

    localparam logic [DRIVE_W-1:0] DRIVE_ONE = DRIVE_W'(1) << DRIVE_FRAC_BITS;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CROSS = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [TARGET_W-1:0] TARGET_RST      = 14'd0;
    localparam logic [GEAR_W-1:0]   GEAR_RST        = 4'd6;
    localparam logic [GAIN_W-1:0]   GAIN_RST        = 16'd4194;
    localparam logic [DRIVE_W-1:0]  FIRST_CROSS_RST = 17'd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_UPDATE,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic start;
        logic err_neg;
    } t_upd_ctrl;

    typedef struct packed {
        logic               done;
        logic [CMD_W-1:0]   cmd;
        logic [DRIVE_W-1:0] drive;
        logic               crossed;
    } t_upd_res;

endpackage

[src/tbh_serial_mult.sv]
// Right-shifting bit-serial multiplier: one bit of the gain per cycle.
module tbh_serial_mult (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tbh_pkg::MAG_W-1:0]     i_mag,
    input  logic [tbh_pkg::GAIN_W-1:0]    i_gain,
    output logic                          o_done,
    output logic [tbh_pkg::PROD_W-1:0]    o_product
);

    localparam int CNT_W = $clog2(tbh_pkg::GAIN_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tbh_pkg::GAIN_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [tbh_pkg::MAG_W-1:0]   r_mag;
    logic [tbh_pkg::GAIN_W-1:0]  r_gain;
    logic [tbh_pkg::MAG_W-1:0]   r_hi;
    logic [tbh_pkg::GAIN_W-1:0]  r_lo;
    logic [tbh_pkg::MAG_W:0]     w_sum;

    assign w_sum = {1'b0, r_hi} + (r_gain[0] ? {1'b0, r_mag} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag  <= i_mag;
            r_gain <= i_gain;
            r_hi   <= '0;
            r_lo   <= '0;
        end else if (r_busy) begin
            r_gain <= r_gain >> 1;
            r_hi   <= w_sum[tbh_pkg::MAG_W:1];
            r_lo   <= {w_sum[0], r_lo[tbh_pkg::GAIN_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

[src/tbh_drive_update.sv]
// Drive integrator and take-back-half reload, four registered steps.
module tbh_drive_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbh_pkg::t_upd_ctrl            i_ctrl,
    input  logic [tbh_pkg::PROD_W-1:0]    i_product,
    input  logic [tbh_pkg::DRIVE_W-1:0]   i_first_cross,
    output tbh_pkg::t_upd_res             o_res
);

    localparam logic [tbh_pkg::PROD_W:0] ROUND_HALF =
        (tbh_pkg::PROD_W + 1)'(1) << (tbh_pkg::SHIFT - 1);
    localparam logic [tbh_pkg::CMDP_W-1:0] CMD_HALF =
        tbh_pkg::CMDP_W'(1) << (tbh_pkg::DRIVE_FRAC_BITS - 1);
    localparam logic [tbh_pkg::CMDP_W-1:0] CMD_SCALE = tbh_pkg::CMDP_W'(tbh_pkg::MAX_COMMAND);
    localparam logic [tbh_pkg::CMD_W:0] CMD_MAX = (tbh_pkg::CMD_W + 1)'(tbh_pkg::MAX_COMMAND);

    logic [3:0]                     r_vld;
    logic [tbh_pkg::DELTA_W-1:0]    r_delta;
    logic [tbh_pkg::DRIVE_W-1:0]    r_clamped;
    logic [tbh_pkg::DRIVE_W-1:0]    r_drive_now;
    logic [tbh_pkg::DRIVE_W-1:0]    r_drive_cross;
    logic                           r_first_pend;
    logic                           r_last_neg;
    logic                           r_crossed;
    logic [tbh_pkg::CMD_W-1:0]      r_cmd;

    logic [tbh_pkg::PROD_W:0]       w_rounded;
    logic signed [tbh_pkg::SUM_W-1:0] w_sum;
    logic [tbh_pkg::DRIVE_W-1:0]    w_clamped;
    logic                           w_crossed;
    logic [tbh_pkg::DRIVE_W:0]      w_avg_sum;
    logic [tbh_pkg::DRIVE_W-1:0]    w_first;
    logic [tbh_pkg::DRIVE_W-1:0]    w_next_drive;
    logic [tbh_pkg::CMDP_W-1:0]     w_cmd_prod;
    logic [tbh_pkg::CMD_W:0]        w_cmd_raw;

    assign w_rounded = {1'b0, i_product} + ROUND_HALF;

    always_comb begin
        if (i_ctrl.err_neg) begin
            w_sum = $signed({{(tbh_pkg::SUM_W - tbh_pkg::DRIVE_W){1'b0}}, r_drive_now})
                  - $signed({2'b00, r_delta});
        end else begin
            w_sum = $signed({{(tbh_pkg::SUM_W - tbh_pkg::DRIVE_W){1'b0}}, r_drive_now})
                  + $signed({2'b00, r_delta});
        end
        if (w_sum[tbh_pkg::SUM_W-1]) begin
            w_clamped = '0;
        end else if (w_sum > $signed(tbh_pkg::SUM_W'(tbh_pkg::DRIVE_ONE))) begin
            w_clamped = tbh_pkg::DRIVE_ONE;
        end else begin
            w_clamped = w_sum[tbh_pkg::DRIVE_W-1:0];
        end
    end

    // The first-crossing value is already in Q1.16, the drive format.
    assign w_first   = (i_first_cross > tbh_pkg::DRIVE_ONE) ? tbh_pkg::DRIVE_ONE : i_first_cross;
    assign w_crossed = i_ctrl.err_neg != r_last_neg;
    assign w_avg_sum = {1'b0, r_clamped} + {1'b0, r_drive_cross};

    always_comb begin
        if (!w_crossed) begin
            w_next_drive = r_clamped;
        end else if (r_first_pend) begin
            w_next_drive = w_first;
        end else begin
            w_next_drive = w_avg_sum[tbh_pkg::DRIVE_W:1];
        end
    end

    assign w_cmd_prod = {{tbh_pkg::CMD_W{1'b0}}, r_drive_now} * CMD_SCALE + CMD_HALF;
    assign w_cmd_raw  = w_cmd_prod[tbh_pkg::CMDP_W-1:tbh_pkg::DRIVE_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_drive_now   <= '0;
            r_drive_cross <= '0;
            r_first_pend  <= 1'b1;
            r_last_neg    <= 1'b0;
        end else begin
            r_vld <= {r_vld[2:0], i_ctrl.start};
            if (r_vld[1]) begin
                r_drive_now <= w_next_drive;
                r_last_neg  <= i_ctrl.err_neg;
                if (w_crossed) begin
                    r_drive_cross <= w_next_drive;
                    r_first_pend  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_delta <= w_rounded[tbh_pkg::PROD_W:tbh_pkg::SHIFT];
        end
        if (r_vld[0]) begin
            r_clamped <= w_clamped;
        end
        if (r_vld[1]) begin
            r_crossed <= w_crossed;
        end
        if (r_vld[2]) begin
            r_cmd <= (w_cmd_raw > CMD_MAX) ? CMD_MAX[tbh_pkg::CMD_W-1:0]
                                           : w_cmd_raw[tbh_pkg::CMD_W-1:0];
        end
    end

    assign o_res.done    = r_vld[3];
    assign o_res.cmd     = r_cmd;
    assign o_res.drive   = r_drive_now;
    assign o_res.crossed = r_crossed;

endmodule

[src/take_back_half_velocity_control.sv]
// Take-back-half flywheel velocity controller. Each input word is one control
// tick carrying the measured motor speed (signed rpm). The speed is scaled by
// the gear ratio, the error against the target velocity is formed, and error
// times loop gain is added to a Q1.16 drive level that saturates to 0..1.
// When the sign of the error flips, the drive is reloaded: on the first flip
// with the configured first-crossing drive, on later flips with the average of
// the current drive and the drive stored at the previous flip. Each tick gives
// exactly one output word with the rounded motor command 0..127, the drive
// level and a zero-crossing flag. After acceptance, where the error is formed,
// a tick passes the bit-serial gain multiplier (one gain bit per cycle), the
// drive update steps and the hand-over to the output register; the next tick
// can be accepted only then, provided the output register is free. The
// bit-serial multiplier is the longest of these steps. A finished word waits
// in the output register, and the next tick is accepted while it waits.
// Configuration registers are written through a plain write port and should
// only change while no tick is in flight.
module take_back_half_velocity_control (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input words: tdata bits [10:0] motor_rpm (signed), [15:11] zero.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,

    // Output words: tdata bits [6:0] motor_command, [23:7] drive_level.
    // tuser bit [0] crossed_zero.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    output logic [0:0]  o_m_axis_tuser,

    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [16:0] i_cfg_data
);

    // Configuration registers.
    logic [tbh_pkg::TARGET_W-1:0] r_target;
    logic [tbh_pkg::GEAR_W-1:0]   r_gear;
    logic [tbh_pkg::GAIN_W-1:0]   r_gain;
    logic [tbh_pkg::DRIVE_W-1:0]  r_first_cross;

    // Sequencer.
    tbh_pkg::t_state r_state;
    tbh_pkg::t_state n_state;

    logic                      r_err_neg;
    logic                      w_accept;
    logic                      w_load_out;
    logic                      w_mul_done;
    logic [tbh_pkg::PROD_W-1:0] w_product;
    tbh_pkg::t_upd_ctrl        w_upd_ctrl;
    tbh_pkg::t_upd_res         w_upd_res;

    // Output register.
    logic                      r_m_valid;
    logic [tbh_pkg::CMD_W-1:0] r_m_cmd;
    logic [tbh_pkg::DRIVE_W-1:0] r_m_drive;
    logic                      r_m_crossed;

    // Error arithmetic: all values fit a 16-bit signed word.
    logic signed [tbh_pkg::ERR_W-1:0] w_rpm_x;
    logic signed [tbh_pkg::ERR_W-1:0] w_gear_x;
    logic signed [tbh_pkg::ERR_W-1:0] w_scaled;
    logic signed [tbh_pkg::ERR_W-1:0] w_err;
    logic [tbh_pkg::ERR_W-1:0]        w_err_abs;
    logic [tbh_pkg::MAG_W-1:0]        w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= tbh_pkg::TARGET_RST;
            r_gear        <= tbh_pkg::GEAR_RST;
            r_gain        <= tbh_pkg::GAIN_RST;
            r_first_cross <= tbh_pkg::FIRST_CROSS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tbh_pkg::REG_TARGET: begin
                    r_target <= i_cfg_data[tbh_pkg::TARGET_W-1:0];
                end
                tbh_pkg::REG_GEAR: begin
                    r_gear <= i_cfg_data[tbh_pkg::GEAR_W-1:0];
                end
                tbh_pkg::REG_GAIN: begin
                    r_gain <= i_cfg_data[tbh_pkg::GAIN_W-1:0];
                end
                tbh_pkg::REG_FIRST_CROSS: begin
                    r_first_cross <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The gear multiply is only 11 by 4 bits, so it sits in the accept cycle.
    assign w_rpm_x   = $signed({{(tbh_pkg::ERR_W - tbh_pkg::RPM_W){i_s_axis_tdata[tbh_pkg::RPM_W-1]}},
                                i_s_axis_tdata[tbh_pkg::RPM_W-1:0]});
    assign w_gear_x  = $signed({{(tbh_pkg::ERR_W - tbh_pkg::GEAR_W){1'b0}}, r_gear});
    assign w_scaled  = w_rpm_x * w_gear_x;
    assign w_err     = $signed({{(tbh_pkg::ERR_W - tbh_pkg::TARGET_W){1'b0}}, r_target}) - w_scaled;
    assign w_err_abs = w_err[tbh_pkg::ERR_W-1] ? (tbh_pkg::ERR_W'(0) - w_err) : w_err;
    assign w_mag     = w_err_abs[tbh_pkg::MAG_W-1:0];

    assign o_s_axis_tready = (r_state == tbh_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The error sign stays stable for the whole tick; the update steps read it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err_neg <= w_err[tbh_pkg::ERR_W-1];
        end
    end

    always_comb begin
        n_state    = r_state;
        w_load_out = 1'b0;
        unique case (r_state)
            tbh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = tbh_pkg::ST_MULT;
                end
            end
            tbh_pkg::ST_MULT: begin
                if (w_mul_done) begin
                    n_state = tbh_pkg::ST_UPDATE;
                end
            end
            tbh_pkg::ST_UPDATE: begin
                if (w_upd_res.done) begin
                    n_state = tbh_pkg::ST_SEND;
                end
            end
            tbh_pkg::ST_SEND: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = tbh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbh_pkg::ST_IDLE;
            end
        endcase
    end

    tbh_serial_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_mag     (w_mag),
        .i_gain    (r_gain),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    assign w_upd_ctrl.start   = (r_state == tbh_pkg::ST_MULT) && w_mul_done;
    assign w_upd_ctrl.err_neg = r_err_neg;

    tbh_drive_update u_update (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_upd_ctrl),
        .i_product     (w_product),
        .i_first_cross (r_first_cross),
        .o_res         (w_upd_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_cmd     <= w_upd_res.cmd;
            r_m_drive   <= w_upd_res.drive;
            r_m_crossed <= w_upd_res.crossed;
        end
    end

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = {r_m_drive, r_m_cmd};
    assign o_m_axis_tuser[0] = r_m_crossed;

endmodule

[src/tbh_checker.sv]
`include "take_back_half_velocity_control_assert.svh"

// Port-level checks of the velocity controller.
module tbh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // The drive never leaves the range 0..1.
    `TBH_ASSERT_SAME(a_drive_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[23:7] <= 17'd65536, "drive level above full scale")

    // Zero drive rounds to a zero command, full drive to the top command.
    `TBH_ASSERT_SAME(a_cmd_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[23:7] == 17'd0, o_m_axis_tdata[6:0] == 7'd0, "nonzero command at zero drive")
    `TBH_ASSERT_SAME(a_cmd_full, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[23:7] == 17'd65536, o_m_axis_tdata[6:0] == 7'd127, "command not full at full drive")

    // One tick at a time: the input side closes right after it takes a word.
    `TBH_ASSERT_NEXT(a_one_tick, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "second word accepted while a tick is in flight")

    // A stalled output word holds.
    `TBH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled output word changed")

endmodule

bind take_back_half_velocity_control tbh_checker u_tbh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
